### rtl/cmap_pkg.sv
// Shared types, codes and field layout for the character-map lookup block.
`timescale 1ns / 1ps

package cmap_pkg;

    localparam int MAX_SEGMENTS_DEF      = 256;
    localparam int GLYPH_ARRAY_DEPTH_DEF = 1024;

    localparam int S_TDATA_W  = 184;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam int OFF_SEG_INDEX   = 0;
    localparam int OFF_SEG_START   = 8;
    localparam int OFF_SEG_END     = 40;
    localparam int OFF_SEG_VALUE   = 72;
    localparam int OFF_SEG_RANGE   = 104;
    localparam int OFF_ARRAY_INDEX = 120;
    localparam int OFF_ARRAY_WORD  = 130;
    localparam int OFF_CODEPOINT   = 146;

    localparam logic [31:0] BMP_MAX = 32'h0000_FFFF;

    localparam logic [1:0] REQ_LOAD_SEG   = 2'd0;
    localparam logic [1:0] REQ_LOAD_ARRAY = 2'd1;
    localparam logic [1:0] REQ_LOOKUP     = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_FORMAT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEGMENT_COUNT = 1'b1;

    localparam logic FMT_SEGMENT4 = 1'b0;
    localparam logic FMT_GROUP12  = 1'b1;

    typedef struct packed {
        logic [15:0] range_offset;
        logic [31:0] value;
        logic [31:0] last_code;
        logic [31:0] start_code;
    } seg_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CALC,
        ST_CHECK,
        ST_GREAD,
        ST_DONE
    } state_t;

endpackage

### rtl/cmap_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cmap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/cmap_codepoint_to_glyph_lookup_core.sv
// Top level of the character-map lookup: table stores, binary search sequencer and output beat.
// A load beat is answered in the cycle after acceptance; the next beat can be taken then only
// if m_tready is high. A lookup makes k <= floor(log2(count)) + 1 segment probes;
// a miss goes to done, a hit to calc, and a format 4 hit with a nonzero range offset via check
// to glyph read. A format 4 codepoint above 0xFFFF or an empty table goes from idle to done.
// Reset is synchronous and active low; it clears the sequencer, the output valid and both
// configuration registers, while the segment and glyph stores hold no reset value.
`timescale 1ns / 1ps

module cmap_codepoint_to_glyph_lookup_core #(
    parameter int MAX_SEGMENTS      = cmap_pkg::MAX_SEGMENTS_DEF,
    parameter int GLYPH_ARRAY_DEPTH = cmap_pkg::GLYPH_ARRAY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cmap_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cmap_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // seg_index, seg_start, seg_end, seg_value, seg_range_offset, array_index,
    // array_word, codepoint; zero padding above
    input  logic [cmap_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [cmap_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // glyph_num, mapped, bad_index; zero padding above
    output logic [cmap_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int GA_AW  = (GLYPH_ARRAY_DEPTH > 1) ? $clog2(GLYPH_ARRAY_DEPTH) : 1;
    localparam int SEG_W  = $bits(cmap_pkg::seg_entry_t);

    cmap_pkg::state_t state_reg, state_next;

    logic                            fmt_reg;
    logic [cmap_pkg::CFG_DATA_W-1:0] seg_count_reg;

    logic [CNT_W-1:0] lo_reg, lo_next, he_reg, he_next, mid_reg, mid_next;
    logic [CNT_W-1:0] lo_new, he_new;
    logic [31:0]      cp_reg, cp_next, off_reg, off_next, val_reg, val_next;
    logic [15:0]      ro_reg, ro_next;
    logic [18:0]      idx_reg, idx_next;
    logic [31:0]      res_glyph_reg, res_glyph_next;
    logic             res_mapped_reg, res_mapped_next, res_bad_reg, res_bad_next;
    logic             out_valid_reg, out_valid_next;
    logic [cmap_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [16:0]      cnt_sat;
    logic [CNT_W-1:0] active_cnt;
    logic             accept_ok;

    logic [1:0]  s_req;
    logic [31:0] s_cp;
    logic [31:0] seg_slot_ext, ga_slot_ext;
    logic        seg_slot_ok, ga_slot_ok;
    logic        seg_we, ga_we;

    cmap_pkg::seg_entry_t seg_wr, seg_rd;
    logic [SEG_W-1:0]     seg_rd_bits;
    logic [15:0]          ga_rd_data;

    logic [31:0] s_cmp, e_cmp;
    logic [32:0] diff;
    logic        below, in_range, idx_bad;

    assign s_req = s_tuser[1:0];
    assign s_cp  = s_tdata[cmap_pkg::OFF_CODEPOINT +: 32];

    assign cnt_sat = (17'(seg_count_reg) > 17'(MAX_SEGMENTS)) ? 17'(MAX_SEGMENTS)
                                                               : 17'(seg_count_reg);
    assign active_cnt = cnt_sat[CNT_W-1:0];

    assign seg_slot_ext = 32'(s_tdata[cmap_pkg::OFF_SEG_INDEX +: 8]);
    assign ga_slot_ext  = 32'(s_tdata[cmap_pkg::OFF_ARRAY_INDEX +: 10]);
    assign seg_slot_ok  = seg_slot_ext < 32'(MAX_SEGMENTS);
    assign ga_slot_ok   = ga_slot_ext < 32'(GLYPH_ARRAY_DEPTH);

    assign seg_wr.start_code   = s_tdata[cmap_pkg::OFF_SEG_START +: 32];
    assign seg_wr.last_code    = s_tdata[cmap_pkg::OFF_SEG_END +: 32];
    assign seg_wr.value        = s_tdata[cmap_pkg::OFF_SEG_VALUE +: 32];
    assign seg_wr.range_offset = s_tdata[cmap_pkg::OFF_SEG_RANGE +: 16];
    assign seg_rd              = cmap_pkg::seg_entry_t'(seg_rd_bits);

    assign s_cmp = (fmt_reg == cmap_pkg::FMT_SEGMENT4) ? {16'd0, seg_rd.start_code[15:0]}
                                                       : seg_rd.start_code;
    assign e_cmp = (fmt_reg == cmap_pkg::FMT_SEGMENT4) ? {16'd0, seg_rd.last_code[15:0]}
                                                       : seg_rd.last_code;
    assign diff     = {1'b0, cp_reg} - {1'b0, s_cmp};
    assign below    = diff[32];
    assign in_range = !below && (cp_reg <= e_cmp);
    assign idx_bad  = idx_reg[18] || (idx_reg[17:0] >= 18'(GLYPH_ARRAY_DEPTH));

    assign accept_ok = aresetn && (state_reg == cmap_pkg::ST_IDLE) &&
                       (!out_valid_reg || m_tready);
    assign s_tready  = accept_ok;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    cmap_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS),
        .AW    (SEG_AW)
    ) u_seg_ram (
        .aclk    (aclk),
        .we      (seg_we),
        .wr_addr (seg_slot_ext[SEG_AW-1:0]),
        .wr_data (seg_wr),
        .rd_addr (mid_next[SEG_AW-1:0]),
        .rd_data (seg_rd_bits)
    );

    cmap_ram #(
        .WIDTH (16),
        .DEPTH (GLYPH_ARRAY_DEPTH),
        .AW    (GA_AW)
    ) u_glyph_ram (
        .aclk    (aclk),
        .we      (ga_we),
        .wr_addr (ga_slot_ext[GA_AW-1:0]),
        .wr_data (s_tdata[cmap_pkg::OFF_ARRAY_WORD +: 16]),
        .rd_addr (idx_reg[GA_AW-1:0]),
        .rd_data (ga_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= cmap_pkg::FMT_SEGMENT4;
            seg_count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                cmap_pkg::CFG_TABLE_FORMAT:  fmt_reg       <= cfg_wdata[0];
                cmap_pkg::CFG_SEGMENT_COUNT: seg_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cmap_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        lo_reg         <= lo_next;
        he_reg         <= he_next;
        mid_reg        <= mid_next;
        cp_reg         <= cp_next;
        off_reg        <= off_next;
        val_reg        <= val_next;
        ro_reg         <= ro_next;
        idx_reg        <= idx_next;
        res_glyph_reg  <= res_glyph_next;
        res_mapped_reg <= res_mapped_next;
        res_bad_reg    <= res_bad_next;
        out_data_reg   <= out_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        he_next         = he_reg;
        mid_next        = mid_reg;
        cp_next         = cp_reg;
        off_next        = off_reg;
        val_next        = val_reg;
        ro_next         = ro_reg;
        idx_next        = idx_reg;
        res_glyph_next  = res_glyph_reg;
        res_mapped_next = res_mapped_reg;
        res_bad_next    = res_bad_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        seg_we          = 1'b0;
        ga_we           = 1'b0;
        lo_new          = lo_reg;
        he_new          = he_reg;

        case (state_reg)
            cmap_pkg::ST_IDLE: begin
                if (s_tvalid && accept_ok) begin
                    case (s_req)
                        cmap_pkg::REQ_LOAD_SEG: begin
                            seg_we         = seg_slot_ok;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                        cmap_pkg::REQ_LOAD_ARRAY: begin
                            ga_we          = ga_slot_ok;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                        cmap_pkg::REQ_LOOKUP: begin
                            cp_next         = s_cp;
                            lo_next         = '0;
                            he_next         = active_cnt;
                            mid_next        = (active_cnt - CNT_W'(1)) >> 1;
                            res_glyph_next  = '0;
                            res_mapped_next = 1'b0;
                            res_bad_next    = 1'b0;
                            if ((active_cnt == '0) ||
                                ((fmt_reg == cmap_pkg::FMT_SEGMENT4) &&
                                 (s_cp > cmap_pkg::BMP_MAX))) begin
                                state_next = cmap_pkg::ST_DONE;
                            end else begin
                                state_next = cmap_pkg::ST_SEARCH;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            cmap_pkg::ST_SEARCH: begin
                off_next = diff[31:0];
                val_next = seg_rd.value;
                ro_next  = seg_rd.range_offset;
                if (in_range) begin
                    res_mapped_next = 1'b1;
                    state_next      = cmap_pkg::ST_CALC;
                end else begin
                    if (below) begin
                        he_new = mid_reg;
                    end else begin
                        lo_new = mid_reg + CNT_W'(1);
                    end
                    lo_next = lo_new;
                    he_next = he_new;
                    if (lo_new < he_new) begin
                        mid_next = lo_new + ((he_new - lo_new - CNT_W'(1)) >> 1);
                    end else begin
                        state_next = cmap_pkg::ST_DONE;
                    end
                end
            end
            cmap_pkg::ST_CALC: begin
                if (fmt_reg == cmap_pkg::FMT_GROUP12) begin
                    res_glyph_next = val_reg + off_reg;
                    state_next     = cmap_pkg::ST_DONE;
                end else if (ro_reg == 16'd0) begin
                    res_glyph_next = {16'd0, cp_reg[15:0] + val_reg[15:0]};
                    state_next     = cmap_pkg::ST_DONE;
                end else begin
                    idx_next   = 19'(ro_reg[15:1]) + 19'(off_reg[15:0]) + 19'(mid_reg)
                               - 19'(active_cnt);
                    state_next = cmap_pkg::ST_CHECK;
                end
            end
            cmap_pkg::ST_CHECK: begin
                if (idx_bad) begin
                    res_bad_next = 1'b1;
                    state_next   = cmap_pkg::ST_DONE;
                end else begin
                    state_next = cmap_pkg::ST_GREAD;
                end
            end
            cmap_pkg::ST_GREAD: begin
                res_glyph_next = (ga_rd_data != 16'd0) ?
                                 {16'd0, ga_rd_data + val_reg[15:0]} : 32'd0;
                state_next     = cmap_pkg::ST_DONE;
            end
            cmap_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, res_bad_reg, res_mapped_reg, res_glyph_reg};
                    state_next     = cmap_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cmap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cmap_checker.sv
// Port-level assertions for the character-map lookup block, bound to its top level.
`timescale 1ns / 1ps

module cmap_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [cmap_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cmap_pkg::M_TDATA_W-1:0] m_tdata
);

    // A result beat that is held back keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // No new beat is taken while the output register is full and stalled.
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    // Load and reserved beats are answered in the next cycle with an all-zero result.
    a_load_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != cmap_pkg::REQ_LOOKUP)
        |=> m_tvalid && (m_tdata[33:0] == 34'd0))
        else $error("load beat not answered with zero result");

    // A bad index is only reported for a mapped codepoint, and never with a glyph.
    a_bad_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> m_tdata[32] && (m_tdata[31:0] == 32'd0))
        else $error("bad index without mapping or with a glyph");

    // After reset no result beat is offered.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind cmap_codepoint_to_glyph_lookup_core cmap_checker u_cmap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/cmap_codepoint_to_glyph_lookup_core_tb.sv
// Self-checking testbench for the character-map lookup core with its own table predictor.
`timescale 1ns / 1ps

module cmap_codepoint_to_glyph_lookup_core_tb;
    import cmap_pkg::*;

    localparam logic [1:0] REQ_RESERVED   = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [31:0] glyph_num;
        logic        mapped;
        logic        bad_index;
    } glyph_result_t;

    typedef struct {
        logic [1:0]    req;
        logic [7:0]    seg_index;
        logic [31:0]   seg_start;
        logic [31:0]   seg_end;
        logic [31:0]   seg_value;
        logic [15:0]   seg_range;
        logic [9:0]    array_index;
        logic [15:0]   array_word;
        logic [31:0]   codepoint;
        glyph_result_t res;
    } lookup_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    cmap_codepoint_to_glyph_lookup_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    logic [31:0] tbl_start  [MAX_SEGMENTS_DEF];
    logic [31:0] tbl_end    [MAX_SEGMENTS_DEF];
    logic [31:0] tbl_value  [MAX_SEGMENTS_DEF];
    logic [15:0] tbl_range  [MAX_SEGMENTS_DEF];
    logic [15:0] tbl_glyphs [GLYPH_ARRAY_DEPTH_DEF];
    bit          seg_loaded [MAX_SEGMENTS_DEF];
    bit          word_loaded[GLYPH_ARRAY_DEPTH_DEF];
    logic        model_fmt   = FMT_SEGMENT4;
    logic [8:0]  model_count = '0;

    lookup_beat_t  beats_to_send[$];
    glyph_result_t glyph_results_due[$];
    lookup_beat_t  in_flight;

    int errors       = 0;
    int n_beats      = 0;
    int n_lookups    = 0;
    int n_mapped     = 0;
    int n_bad        = 0;
    int n_results    = 0;
    int n_cfg_writes = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_tick   = 0;
    int stall_mode   = 0;
    int quiet_cycles = 0;

    function automatic int active_segments();
        return (model_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(model_count);
    endfunction

    // Binary search over the active segments; unsafe is set when an entry never written is read.
    function automatic glyph_result_t map_codepoint(input logic [31:0] cp, output bit unsafe);
        glyph_result_t r;
        int            cnt;
        int            lo;
        int            hi;
        int            mid;
        logic [31:0]   s;
        logic [31:0]   e;
        logic [31:0]   off;
        logic [15:0]   delta;
        logic [15:0]   ro;
        logic [15:0]   id;
        longint        idx;
        bit            f4;
        r      = '{default: '0};
        unsafe = 1'b0;
        cnt    = active_segments();
        f4     = (model_fmt == FMT_SEGMENT4);
        if (f4 && cp > BMP_MAX) return r;
        lo = 0;
        hi = cnt - 1;
        while (lo <= hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (!seg_loaded[mid]) unsafe = 1'b1;
            s = tbl_start[mid];
            e = tbl_end[mid];
            if (f4) begin
                s = {16'h0, s[15:0]};
                e = {16'h0, e[15:0]};
            end
            if (s <= cp && cp <= e) begin
                r.mapped = 1'b1;
                off      = cp - s;
                if (!f4) begin
                    r.glyph_num = tbl_value[mid] + off;
                end else begin
                    delta = tbl_value[mid][15:0];
                    ro    = tbl_range[mid];
                    if (ro == 16'h0) begin
                        r.glyph_num = {16'h0, 16'(cp[15:0] + delta)};
                    end else begin
                        idx = longint'(ro >> 1) + longint'(off) + longint'(mid) - longint'(cnt);
                        if (idx < 0 || idx >= GLYPH_ARRAY_DEPTH_DEF) begin
                            r.bad_index = 1'b1;
                        end else begin
                            if (!word_loaded[idx]) unsafe = 1'b1;
                            id          = tbl_glyphs[idx];
                            r.glyph_num = (id == 16'h0) ? 32'h0 : {16'h0, 16'(id + delta)};
                        end
                    end
                end
                return r;
            end else if (s > cp) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return r;
    endfunction

    function automatic glyph_result_t apply_beat(input lookup_beat_t b);
        glyph_result_t r;
        bit            unsafe;
        r = '{default: '0};
        case (b.req)
            REQ_LOAD_SEG: begin
                tbl_start[b.seg_index]  = b.seg_start;
                tbl_end[b.seg_index]    = b.seg_end;
                tbl_value[b.seg_index]  = b.seg_value;
                tbl_range[b.seg_index]  = b.seg_range;
                seg_loaded[b.seg_index] = 1'b1;
            end
            REQ_LOAD_ARRAY: begin
                tbl_glyphs[b.array_index]  = b.array_word;
                word_loaded[b.array_index] = 1'b1;
            end
            REQ_LOOKUP: begin
                r = map_codepoint(b.codepoint, unsafe);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_beat(input lookup_beat_t b);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFF_SEG_INDEX   +: 8]  = b.seg_index;
        d[OFF_SEG_START   +: 32] = b.seg_start;
        d[OFF_SEG_END     +: 32] = b.seg_end;
        d[OFF_SEG_VALUE   +: 32] = b.seg_value;
        d[OFF_SEG_RANGE   +: 16] = b.seg_range;
        d[OFF_ARRAY_INDEX +: 10] = b.array_index;
        d[OFF_ARRAY_WORD  +: 16] = b.array_word;
        d[OFF_CODEPOINT   +: 32] = b.codepoint;
        return d;
    endfunction

    // Fields that the request type does not use carry random values.
    function automatic lookup_beat_t random_beat(input logic [1:0] req);
        lookup_beat_t b;
        b.req         = req;
        b.seg_index   = 8'($urandom);
        b.seg_start   = $urandom;
        b.seg_end     = $urandom;
        b.seg_value   = $urandom;
        b.seg_range   = 16'($urandom);
        b.array_index = 10'($urandom);
        b.array_word  = 16'($urandom);
        b.codepoint   = $urandom;
        b.res         = '{default: '0};
        return b;
    endfunction

    task automatic queue_beat(input lookup_beat_t b);
        b.res = apply_beat(b);
        beats_to_send.push_back(b);
        n_beats++;
        if (b.req == REQ_LOOKUP) begin
            n_lookups++;
            if (b.res.mapped) n_mapped++;
            if (b.res.bad_index) n_bad++;
        end
    endtask

    task automatic queue_segment_load(input logic [7:0] slot, input logic [31:0] s,
                                      input logic [31:0] e, input logic [31:0] v,
                                      input logic [15:0] ro);
        lookup_beat_t b;
        b           = random_beat(REQ_LOAD_SEG);
        b.seg_index = slot;
        b.seg_start = s;
        b.seg_end   = e;
        b.seg_value = v;
        b.seg_range = ro;
        queue_beat(b);
    endtask

    task automatic queue_array_load(input logic [9:0] idx, input logic [15:0] word);
        lookup_beat_t b;
        b             = random_beat(REQ_LOAD_ARRAY);
        b.array_index = idx;
        b.array_word  = word;
        queue_beat(b);
    endtask

    // A lookup that would read a store entry never written is sent as a reserved beat instead.
    task automatic queue_lookup(input logic [31:0] cp);
        lookup_beat_t  b;
        glyph_result_t r;
        bit            unsafe;
        r = map_codepoint(cp, unsafe);
        if (unsafe) begin
            b = random_beat(REQ_RESERVED);
        end else begin
            b           = random_beat(REQ_LOOKUP);
            b.codepoint = cp;
        end
        queue_beat(b);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (beats_to_send.size() != 0 || s_tvalid || glyph_results_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == CFG_TABLE_FORMAT) model_fmt = value[0];
        else model_count = value[8:0];
        n_cfg_writes++;
        @(negedge aclk);
    endtask

    task automatic load_table(input logic fmt, input int n, input bit scrambled,
                              input int max_win);
        longint      step;
        longint      st;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] len;
        logic [15:0] ro;
        int          kind;
        int          b;
        int          t;
        int          idx;
        write_reg(CFG_TABLE_FORMAT, {31'h0, fmt});
        write_reg(CFG_SEGMENT_COUNT, n);
        for (int i = 0; i < n; i++) begin
            ro = 16'h0;
            if (scrambled) begin
                s  = $urandom;
                e  = $urandom;
                ro = $urandom_range(0, 1) ? 16'h0 : 16'($urandom);
            end else if (fmt == FMT_GROUP12) begin
                step = 64'h1_0000_0000 / n;
                st   = longint'(i) * step + $urandom_range(0, 32'(step / 4));
                len  = $urandom_range(0, 32'(step / 2));
                s    = 32'(st);
                e    = s + len;
                ro   = 16'($urandom);
            end else begin
                step = 65536 / n;
                kind = $urandom_range(0, 9);
                len  = (kind >= 4) ? $urandom_range(0, max_win) : $urandom_range(0, 32'(step / 2));
                st   = longint'(i) * step + $urandom_range(0, 32'(step / 4));
                s    = {16'($urandom), 16'(st)};
                e    = {16'($urandom), 16'(st + len)};
                if (kind >= 4 && kind <= 7) begin
                    b  = $urandom_range(0, 1023 - len);
                    ro = 16'(2 * (b + n - i) + int'($urandom_range(0, 1)));
                end else if (kind == 8) begin
                    ro = 16'($urandom_range(1, 65535));
                end else if (kind == 9) begin
                    b  = $urandom_range(0, 1) ? -int'($urandom_range(1, 4))
                                              : 1024 - int'($urandom_range(0, len));
                    t  = b + n - i;
                    ro = (t > 0) ? 16'(2 * t) : 16'h1;
                end
                if (kind == 9 || (kind >= 4 && kind <= 7)) begin
                    for (int k = 0; k <= int'(len); k++) begin
                        idx = b + k;
                        if (idx >= 0 && idx < GLYPH_ARRAY_DEPTH_DEF)
                            queue_array_load(10'(idx), ($urandom_range(0, 5) == 0) ?
                                             16'h0 : 16'($urandom));
                    end
                end
            end
            queue_segment_load(8'(i), s, e, $urandom, ro);
        end
    endtask

    task automatic run_lookups(input int count);
        int          cnt;
        int          j;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] cp;
        int          kind;
        cnt = active_segments();
        repeat (count) begin
            kind = $urandom_range(0, 19);
            s    = 32'h0;
            e    = 32'h0;
            if (cnt > 0) begin
                j = $urandom_range(0, cnt - 1);
                s = tbl_start[j];
                e = tbl_end[j];
                if (model_fmt == FMT_SEGMENT4) begin
                    s = {16'h0, s[15:0]};
                    e = {16'h0, e[15:0]};
                end
            end
            if (cnt == 0 && kind <= 14) kind = 15;
            if (kind <= 12) begin
                cp = (e >= s) ? s + $urandom_range(0, e - s) : s;
            end else if (kind <= 14) begin
                cp = (kind == 13) ? s - 32'd1 : e + 32'd1;
            end else if (kind <= 16) begin
                cp = (model_fmt == FMT_SEGMENT4) ? $urandom_range(0, 65535) : $urandom;
            end else if (kind == 17) begin
                cp = $urandom | 32'h0001_0000;
            end else if (kind == 18) begin
                case ($urandom_range(0, 2))
                    0:       cp = 32'h0;
                    1:       cp = BMP_MAX;
                    default: cp = 32'hFFFF_FFFF;
                endcase
            end
            if (kind == 19) begin
                if ($urandom_range(0, 1)) queue_array_load(10'($urandom), 16'($urandom));
                else queue_beat(random_beat(REQ_RESERVED));
            end else begin
                queue_lookup(cp);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) glyph_results_due.push_back(in_flight.res);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    in_flight = beats_to_send.pop_front();
                    s_tdata   <= pack_beat(in_flight);
                    s_tuser   <= in_flight.req;
                    s_tvalid  <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 31);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            stall_tick++;
            if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (stall_tick % 16 >= 6);
            endcase
        end
    end

    always @(posedge aclk) begin
        glyph_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (glyph_results_due.size() == 0) begin
                if (errors < 10) $display("unexpected result beat: m_tdata=%h", m_tdata);
                errors++;
            end else begin
                want = glyph_results_due.pop_front();
                if (m_tdata[31:0] !== want.glyph_num || m_tdata[32] !== want.mapped ||
                    m_tdata[33] !== want.bad_index) begin
                    if (errors < 10)
                        $display("result %0d mismatch: glyph %h/%h mapped %b/%b bad %b/%b",
                                 n_results, m_tdata[31:0], want.glyph_num, m_tdata[32],
                                 want.mapped, m_tdata[33], want.bad_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("cmap_codepoint_to_glyph_lookup_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Format 4: direct delta with wrap, glyph array with a zero word, bad index, edges.
        load_table(FMT_SEGMENT4, 0, 1'b0, 0);
        write_reg(CFG_SEGMENT_COUNT, 4);
        queue_segment_load(8'd0, 32'h5A5A_0000, 32'hFFFF_0010, 32'h0000_FFFF, 16'h0);
        queue_segment_load(8'd1, 32'h0000_0100, 32'h0000_0107, 32'h0000_0010, 16'd6);
        queue_segment_load(8'd2, 32'h0000_0200, 32'h0000_0210, 32'h0, 16'hFFFE);
        queue_segment_load(8'd3, 32'h0000_FF00, 32'h0000_FFFF, 32'h1234_0100, 16'h0);
        queue_array_load(10'd0, 16'h0020);
        queue_array_load(10'd1, 16'h0000);
        queue_array_load(10'd2, 16'hFFF5);
        queue_array_load(10'd1023, 16'hFFFF);
        queue_lookup(32'h0);
        queue_lookup(32'h10);
        queue_lookup(32'h11);
        queue_lookup(32'h100);
        queue_lookup(32'h101);
        queue_lookup(32'h102);
        queue_lookup(32'h205);
        queue_lookup(BMP_MAX);
        queue_lookup(32'h0001_0000);
        queue_lookup(32'hFFFF_FFFF);
        queue_beat(random_beat(REQ_RESERVED));

        // Format 12 with wrapping sums, then an empty table.
        write_reg(CFG_TABLE_FORMAT, 32'(FMT_GROUP12));
        write_reg(CFG_SEGMENT_COUNT, 2);
        queue_segment_load(8'd0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 16'h0);
        queue_segment_load(8'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0);
        queue_lookup(32'h0);
        queue_lookup(32'h20);
        queue_lookup(32'hFFFF_FFFF);
        write_reg(CFG_SEGMENT_COUNT, 0);
        queue_lookup(32'h41);

        // Full table, then a count beyond the maximum and a change of format on the same table.
        load_table(FMT_SEGMENT4, MAX_SEGMENTS_DEF, 1'b0, 3);
        run_lookups(80);
        write_reg(CFG_SEGMENT_COUNT, 511);
        run_lookups(30);
        write_reg(CFG_SEGMENT_COUNT, 300);
        write_reg(CFG_TABLE_FORMAT, 32'(FMT_GROUP12));
        run_lookups(20);

        while (n_beats < 1450) begin
            load_table(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                       ($urandom_range(0, 7) == 0), 7);
            run_lookups($urandom_range(15, 40));
        end

        wait_idle();
        repeat (16) @(negedge aclk);
        $display("run covered %0d beats with %0d lookups (%0d mapped, %0d with a bad array index)",
                 n_beats, n_lookups, n_mapped, n_bad);
        $display("over %0d register writes spanning both formats and counts from 0 to 511",
                 n_cfg_writes);
        if (errors == 0 && glyph_results_due.size() == 0) begin
            $display("cmap_codepoint_to_glyph_lookup_core_tb: done, clean");
        end else begin
            $display("cmap_codepoint_to_glyph_lookup_core_tb: done, errors");
        end
        $finish;
    end

endmodule
